// ===== sv/ffha_pkg.sv =====
// ============================================================================
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ============================================================================
package ffha_pkg;

    // Default sizing, overridable on the top level
    localparam int HEAP_BYTES_DEF    = 1 * 1024 * 1024;
    localparam int HEADER_BYTES_DEF  = 24;
    localparam int MIN_REMAINDER_DEF = 8;

    // Fixed field width of the request/result payload
    localparam int FIELD_W = 21;

    // Block alignment: sizes round up to 8, headers are indexed by pos / 8
    localparam int ALIGN    = 8;
    localparam int ALIGN_SH = 3;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [FIELD_W-1:0]  request_size;
        logic [FIELD_W-1:0]  block_offset;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0]  data_offset;
        logic                success;
    } t_rsp;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // Header store access controls
    typedef struct packed {
        logic rd;
        logic wr;
        logic wfree;
    } t_hs_ctl;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_A_NEED,
        S_A_EV,
        S_A_NEXT,
        S_A_FIT,
        S_A_SPL1,
        S_A_SPL2,
        S_A_SPL3,
        S_A_DONE,
        S_F_TGT,
        S_F_CHK,
        S_F_EV,
        S_F_MARK,
        S_M_RD,
        S_M_EV,
        S_M_NXT,
        S_M_EV2
    } t_state;

endpackage

// ===== sv/first_fit_heap_allocator.sv =====
// ============================================================================
// first_fit_heap_allocator
// First-fit heap allocator with block split on allocate and coalesce on free.
// ============================================================================
// Usage:
//   Drive i_req and raise start while busy is low; the request is taken at
//   that clock edge and busy rises until the result is out. The result shows
//   on o_rsp for exactly one cycle with o_done high; the receiver cannot
//   stall it. busy is already low in that cycle, so a new request may follow.
//   Timing is set by the header walk: each header is one read of the
//   single-port header store followed by one pass through the shared adder.
//   An allocate walks the blocks until one fits, then may split it; a free
//   walks to its target block, then walks the whole heap to merge free
//   pairs. A null free, or a nonzero offset below the header, is answered
//   straight from idle, so busy does not rise for it.
//   Reset (synchronous, active low) leaves the heap as one free block; no
//   clearing pass is needed, so requests are taken right after reset.
// ============================================================================
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MIN_REMAINDER = ffha_pkg::MIN_REMAINDER_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ffha_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output ffha_pkg::t_rsp o_rsp
);
    import ffha_pkg::*;

    localparam int HEAP_W = $clog2(HEAP_BYTES + 1);
    localparam int AW     = ((HEAP_W > FIELD_W + 1) ? HEAP_W : FIELD_W + 1) + 1;
    localparam int SZ_W   = $clog2(HEAP_BYTES);
    localparam logic [AW-1:0] HEAP_END  = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] HDR_K     = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] HDR_MIN_K = AW'(HEADER_BYTES + MIN_REMAINDER);
    localparam logic [AW-1:0] RND_K     = AW'(ALIGN - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_need, n_need;
    logic [AW-1:0] r_tgt, n_tgt;
    logic [AW-1:0] r_aux, n_aux;
    logic [AW-1:0] r_sz, n_sz;
    logic          r_free, n_free;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;

    t_alu_op       alu_op;
    logic [AW-1:0] alu_a, alu_b, alu_c, alu_res;
    logic          alu_ge, alu_zero;

    t_hs_ctl       st_ctl;
    logic [AW-1:0] st_pos, st_wsize;
    logic [SZ_W-1:0] st_size;
    logic          st_free;
    logic [AW-1:0] sz_rd;
    logic [AW-1:0] req_size_x;
    logic [AW-1:0] req_off_x;

    assign sz_rd      = {{(AW-SZ_W){1'b0}}, st_size};
    assign req_size_x = {{(AW-FIELD_W){1'b0}}, i_req.request_size};
    assign req_off_x  = {{(AW-FIELD_W){1'b0}}, i_req.block_offset};

    ffha_alu #(
        .AW (AW)
    ) u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_c    (alu_c),
        .o_res  (alu_res),
        .o_ge   (alu_ge),
        .o_zero (alu_zero)
    );

    ffha_hdr_store #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .AW           (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (st_ctl),
        .i_pos   (st_pos),
        .i_wsize (st_wsize),
        .o_size  (st_size),
        .o_free  (st_free)
    );

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_need <= n_need;
        r_tgt  <= n_tgt;
        r_aux  <= n_aux;
        r_sz   <= n_sz;
        r_free <= n_free;
        r_rsp  <= n_rsp;
    end

    // Sequencer: next state, adder operands, store accesses
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_need   = r_need;
        n_tgt    = r_tgt;
        n_aux    = r_aux;
        n_sz     = r_sz;
        n_free   = r_free;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        alu_op   = ALU_ADD;
        alu_a    = r_pos;
        alu_b    = '0;
        alu_c    = '0;
        st_ctl   = '0;
        st_pos   = r_pos;
        st_wsize = r_sz;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.command == CMD_ALLOC) begin
                        n_need  = req_size_x;
                        n_state = S_A_NEED;
                    end else if (req_off_x == '0) begin
                        // null free
                        n_done = 1'b1;
                        n_rsp  = '{data_offset: '0, success: 1'b1};
                    end else if (req_off_x < HDR_K) begin
                        n_done = 1'b1;
                        n_rsp  = '{data_offset: '0, success: 1'b0};
                    end else begin
                        n_tgt   = req_off_x;
                        n_state = S_F_TGT;
                    end
                end
            end

            // ---- allocate ----
            S_A_NEED: begin
                alu_a      = r_need;
                alu_c      = RND_K;
                n_need     = {alu_res[AW-1:ALIGN_SH], {ALIGN_SH{1'b0}}};
                n_pos      = '0;
                st_pos     = '0;
                st_ctl.rd  = 1'b1;
                n_state    = S_A_EV;
            end

            S_A_EV: begin
                alu_op  = ALU_SUB;
                alu_a   = sz_rd;
                alu_b   = r_need;
                n_sz    = sz_rd;
                n_free  = st_free;
                n_state = (st_free && alu_ge) ? S_A_FIT : S_A_NEXT;
            end

            S_A_NEXT: begin
                alu_a = r_pos;
                alu_b = r_sz;
                alu_c = HDR_K;
                if (r_sz > HEAP_END || alu_res >= HEAP_END) begin
                    n_done  = 1'b1;
                    n_rsp   = '{data_offset: '0, success: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_pos     = alu_res;
                    st_pos    = alu_res;
                    st_ctl.rd = 1'b1;
                    n_state   = S_A_EV;
                end
            end

            S_A_FIT: begin
                // split only when the rest holds a header plus the minimum
                alu_op = ALU_SUB;
                alu_a  = r_sz;
                alu_b  = r_need;
                alu_c  = HDR_MIN_K;
                if (alu_ge) begin
                    n_state = S_A_SPL1;
                end else begin
                    st_ctl.wr = 1'b1;
                    st_wsize  = r_sz;
                    n_state   = S_A_DONE;
                end
            end

            S_A_SPL1: begin
                alu_a   = r_pos;
                alu_b   = r_need;
                alu_c   = HDR_K;
                n_aux   = alu_res;
                n_state = S_A_SPL2;
            end

            S_A_SPL2: begin
                alu_op       = ALU_SUB;
                alu_a        = r_sz;
                alu_b        = r_need;
                alu_c        = HDR_K;
                st_pos       = r_aux;
                st_wsize     = alu_res;
                st_ctl.wr    = 1'b1;
                st_ctl.wfree = 1'b1;
                n_state      = S_A_SPL3;
            end

            S_A_SPL3: begin
                st_wsize  = r_need;
                st_ctl.wr = 1'b1;
                n_state   = S_A_DONE;
            end

            S_A_DONE: begin
                alu_a   = r_pos;
                alu_c   = HDR_K;
                n_done  = 1'b1;
                n_rsp   = '{data_offset: alu_res[FIELD_W-1:0], success: 1'b1};
                n_state = S_IDLE;
            end

            // ---- free: find the block ----
            S_F_TGT: begin
                alu_op  = ALU_SUB;
                alu_a   = r_tgt;
                alu_c   = HDR_K;
                n_tgt   = alu_res;
                n_pos   = '0;
                n_state = S_F_CHK;
            end

            S_F_CHK: begin
                alu_op = ALU_SUB;
                alu_a  = r_pos;
                alu_b  = r_tgt;
                if (r_pos < HEAP_END && !alu_ge) begin
                    st_ctl.rd = 1'b1;
                    n_state   = S_F_EV;
                end else if (!alu_zero || r_pos >= HEAP_END) begin
                    n_done  = 1'b1;
                    n_rsp   = '{data_offset: '0, success: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    st_ctl.rd = 1'b1;
                    n_state   = S_F_MARK;
                end
            end

            S_F_EV: begin
                alu_a = r_pos;
                alu_b = sz_rd;
                alu_c = HDR_K;
                if (sz_rd > HEAP_END) begin
                    n_done  = 1'b1;
                    n_rsp   = '{data_offset: '0, success: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_pos   = alu_res;
                    n_state = S_F_CHK;
                end
            end

            S_F_MARK: begin
                st_wsize     = sz_rd;
                st_ctl.wr    = 1'b1;
                st_ctl.wfree = 1'b1;
                n_pos        = '0;
                n_state      = S_M_RD;
            end

            // ---- free: coalesce walk ----
            S_M_RD: begin
                st_ctl.rd = 1'b1;
                n_state   = S_M_EV;
            end

            S_M_EV: begin
                n_sz    = sz_rd;
                n_free  = st_free;
                n_state = S_M_NXT;
            end

            S_M_NXT: begin
                alu_a = r_pos;
                alu_b = r_sz;
                alu_c = HDR_K;
                if (r_sz > HEAP_END || alu_res >= HEAP_END) begin
                    n_done  = 1'b1;
                    n_rsp   = '{data_offset: '0, success: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    n_aux     = alu_res;
                    st_pos    = alu_res;
                    st_ctl.rd = 1'b1;
                    n_state   = S_M_EV2;
                end
            end

            S_M_EV2: begin
                alu_a = r_sz;
                alu_b = sz_rd;
                alu_c = HDR_K;
                if (r_free && st_free) begin
                    // absorb the next block, stay at this one
                    st_wsize     = alu_res;
                    st_ctl.wr    = 1'b1;
                    st_ctl.wfree = 1'b1;
                    n_sz         = alu_res;
                end else begin
                    n_pos  = r_aux;
                    n_sz   = sz_rd;
                    n_free = st_free;
                end
                n_state = S_M_NXT;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // ---- checks ----
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request neither started nor finished");

    a_store_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st_ctl.rd && st_ctl.wr))
        else $error("header store read and written in one cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.success) |-> (o_rsp.data_offset == '0))
        else $error("failed request returned a nonzero offset");

    a_split_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_SPL2) |-> (r_aux > r_pos))
        else $error("split header placed at or below its parent");

endmodule

// ===== sv/ffha_ram.sv =====
// ============================================================================
// ffha_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module ffha_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single address port shared by the write and the registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ffha_alu.sv =====
// ============================================================================
// ffha_alu
// Shared three-operand adder/subtractor with sign and zero flags.
// ============================================================================
module ffha_alu #(
    parameter int AW = 23
) (
    input  ffha_pkg::t_alu_op i_op,
    input  logic [AW-1:0]     i_a,
    input  logic [AW-1:0]     i_b,
    input  logic [AW-1:0]     i_c,
    output logic [AW-1:0]     o_res,
    output logic              o_ge,
    output logic              o_zero
);
    import ffha_pkg::*;

    logic [AW+1:0] a_x;
    logic [AW+1:0] b_x;
    logic [AW+1:0] c_x;
    logic [AW+1:0] sum;

    assign a_x = {2'b00, i_a};
    assign b_x = {2'b00, i_b};
    assign c_x = {2'b00, i_c};

    // a + b + c, or a - b - c; two guard bits keep the sign
    always_comb begin
        unique case (i_op)
            ALU_ADD: sum = a_x + b_x + c_x;
            ALU_SUB: sum = a_x - b_x - c_x;
            default: sum = a_x;
        endcase
    end

    assign o_res  = sum[AW-1:0];
    assign o_ge   = ~sum[AW+1];
    assign o_zero = (sum == '0);

endmodule

// ===== sv/ffha_hdr_store.sv =====
// ============================================================================
// ffha_hdr_store
// Block header store: one entry per 8-byte slot, indexed by block start / 8.
// ============================================================================
module ffha_hdr_store #(
    parameter int  HEAP_BYTES   = 1048576,
    parameter int  HEADER_BYTES = 24,
    parameter int  AW           = 23,
    localparam int SZ_W         = $clog2(HEAP_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffha_pkg::t_hs_ctl i_ctl,
    input  logic [AW-1:0]     i_pos,
    input  logic [AW-1:0]     i_wsize,
    output logic [SZ_W-1:0]   o_size,
    output logic              o_free
);
    import ffha_pkg::*;

    localparam int SLOTS = HEAP_BYTES / ALIGN;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int E_W   = SZ_W + 1;
    localparam logic [AW-1:0]   POS_LIMIT = AW'(SLOTS * ALIGN);
    localparam logic [SZ_W-1:0] INIT_SIZE = SZ_W'(HEAP_BYTES - HEADER_BYTES);

    logic [AW-1:0]    slot;
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             we;
    logic             at_zero;
    logic [E_W-1:0]   ram_rdata;
    logic             r_e0_wr;
    logic             r_rd_oor;
    logic             r_rd_init;

    // Address decode; slots past the heap read as zero and drop writes
    assign slot     = i_pos >> ALIGN_SH;
    assign idx      = slot[IDX_W-1:0];
    assign in_range = (i_pos < POS_LIMIT);
    assign we       = i_ctl.wr && in_range;
    assign at_zero  = (idx == '0);

    ffha_ram #(
        .WIDTH (E_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_re    (i_ctl.rd),
        .i_addr  (idx),
        .i_wdata ({i_wsize[SZ_W-1:0], i_ctl.wfree}),
        .o_rdata (ram_rdata)
    );

    // Entry 0 holds the whole heap as one free block until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_wr   <= 1'b0;
            r_rd_oor  <= 1'b0;
            r_rd_init <= 1'b0;
        end else begin
            if (we && at_zero) begin
                r_e0_wr <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_oor  <= ~in_range;
                r_rd_init <= in_range && at_zero && !r_e0_wr;
            end
        end
    end

    // Read data select
    always_comb begin
        if (r_rd_oor) begin
            o_size = '0;
            o_free = 1'b0;
        end else if (r_rd_init) begin
            o_size = INIT_SIZE;
            o_free = 1'b1;
        end else begin
            o_size = ram_rdata[E_W-1:1];
            o_free = ram_rdata[0];
        end
    end

endmodule

// ===== tb/first_fit_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// first_fit_heap_allocator_tb
// Self-checking regression for the first-fit heap allocator. A driver issues
// allocate and free requests from a queue, with random gaps. A heap model
// predicts every response. A monitor compares each response field by field.
// ============================================================================
module first_fit_heap_allocator_tb;

    import ffha_pkg::*;

    // Heap geometry, matching the default sizing of the block
    localparam int unsigned HEAP  = HEAP_BYTES_DEF;
    localparam int unsigned HDR   = HEADER_BYTES_DEF;
    localparam int unsigned MINR  = MIN_REMAINDER_DEF;
    localparam int unsigned SLOTS = HEAP / ALIGN;
    localparam int unsigned FMAX  = (1 << FIELD_W) - 1;

    localparam int N_RANDOM   = 450;
    localparam int LIVE_CAP   = 40;     // bounds the chain length, and so the walk time
    localparam int STALE_CAP  = 16;
    localparam int IDLE_PCT   = 34;
    localparam int QUIET_LO   = 200;    // no gaps from this many accepted requests until QUIET_HI
    localparam int QUIET_HI   = 320;
    localparam int WDOG_LIMIT = 100000;
    localparam int DRAIN      = 32;
    localparam int MAX_SHOWN  = 10;

    typedef enum {
        STIM_FIXED,
        STIM_ALLOC,
        STIM_FREE_LIVE,
        STIM_FREE_STALE
    } t_stim_kind;

    typedef struct {
        t_stim_kind kind;
        t_req       req;
    } t_stim;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    first_fit_heap_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Heap model: one header per 8-byte slot, data size plus free mark
    // ------------------------------------------------------------------------
    int unsigned blk_size [SLOTS];
    bit          blk_free [SLOTS];

    function automatic int unsigned hdr_size(int unsigned pos);
        return ((pos >> ALIGN_SH) < SLOTS) ? blk_size[pos >> ALIGN_SH] : 0;
    endfunction

    function automatic bit hdr_is_free(int unsigned pos);
        return ((pos >> ALIGN_SH) < SLOTS) ? blk_free[pos >> ALIGN_SH] : 1'b0;
    endfunction

    function automatic void hdr_write(int unsigned pos, int unsigned sz, bit fr);
        if ((pos >> ALIGN_SH) < SLOTS) begin
            blk_size[pos >> ALIGN_SH] = sz;
            blk_free[pos >> ALIGN_SH] = fr;
        end
    endfunction

    // First fit, splitting off the tail when it can hold a header and a minimum block
    function automatic t_rsp heap_alloc(int unsigned req_bytes);
        t_rsp        r;
        int unsigned need;
        int unsigned pos;
        int unsigned sz;
        r    = '0;
        need = (req_bytes + 7) & ~32'd7;
        pos  = 0;
        while (pos < HEAP) begin
            sz = hdr_size(pos);
            if (hdr_is_free(pos) && sz >= need) begin
                if (sz >= need + HDR + MINR) begin
                    hdr_write(pos + HDR + need, sz - need - HDR, 1'b1);
                    sz = need;
                end
                hdr_write(pos, sz, 1'b0);
                r.data_offset = FIELD_W'(pos + HDR);
                r.success     = 1'b1;
                return r;
            end
            if (sz > HEAP) break;
            pos = pos + HDR + sz;
        end
        return r;
    endfunction

    // Coalesce every adjacent free pair, walking from the start of the heap
    function automatic void heap_merge();
        int unsigned pos;
        int unsigned sz;
        int unsigned nxt;
        pos = 0;
        while (pos < HEAP) begin
            sz = hdr_size(pos);
            if (sz > HEAP) break;
            nxt = pos + HDR + sz;
            if (nxt >= HEAP) break;
            if (hdr_is_free(pos) && hdr_is_free(nxt))
                hdr_write(pos, sz + HDR + hdr_size(nxt), 1'b1);
            else
                pos = nxt;
        end
    endfunction

    function automatic bit heap_free(int unsigned off);
        int unsigned target;
        int unsigned pos;
        int unsigned sz;
        if (off == 0) return 1'b1;
        if (off < HDR) return 1'b0;
        target = off - HDR;
        pos    = 0;
        while (pos < HEAP && pos < target) begin
            sz = hdr_size(pos);
            if (sz > HEAP) return 1'b0;
            pos = pos + HDR + sz;
        end
        if (pos != target || pos >= HEAP) return 1'b0;
        hdr_write(pos, hdr_size(pos), 1'b1);
        heap_merge();
        return 1'b1;
    endfunction

    function automatic t_rsp heap_command(t_req q);
        t_rsp r;
        r = '0;
        if (q.command == CMD_ALLOC)
            r = heap_alloc(32'(q.request_size));
        else
            r.success = heap_free(32'(q.block_offset));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Offsets handed out and released, used to aim frees
    // ------------------------------------------------------------------------
    int unsigned live_offs[$];
    int unsigned stale_offs[$];

    function automatic void track_offsets(t_req q, t_rsp r);
        if (q.command == CMD_ALLOC) begin
            if (r.success) live_offs.push_back(32'(r.data_offset));
        end else if (r.success && q.block_offset != 0) begin
            for (int i = 0; i < live_offs.size(); i++) begin
                if (live_offs[i] == q.block_offset) begin
                    live_offs.delete(i);
                    break;
                end
            end
            stale_offs.push_back(32'(q.block_offset));
            if (stale_offs.size() > STALE_CAP) void'(stale_offs.pop_front());
        end
    endfunction

    // Turn a planned request into a concrete one against the current heap
    function automatic t_req resolve_stim(t_stim s);
        t_req q;
        q = s.req;
        case (s.kind)
            STIM_ALLOC: begin
                if (live_offs.size() >= LIVE_CAP) begin
                    q.command      = CMD_FREE;
                    q.block_offset =
                        FIELD_W'(live_offs[$urandom_range(0, live_offs.size() - 1)]);
                end
            end
            STIM_FREE_LIVE: begin
                if (live_offs.size() == 0) begin
                    q.command      = CMD_ALLOC;
                    q.request_size = FIELD_W'($urandom_range(0, 64));
                end else begin
                    q.block_offset =
                        FIELD_W'(live_offs[$urandom_range(0, live_offs.size() - 1)]);
                end
            end
            STIM_FREE_STALE: begin
                if (stale_offs.size() != 0)
                    q.block_offset =
                        FIELD_W'(stale_offs[$urandom_range(0, stale_offs.size() - 1)]);
            end
            default: ;
        endcase
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Request queue; the ignored field of each request carries random noise
    // ------------------------------------------------------------------------
    t_stim stim_q[$];

    function automatic void push_stim(t_stim_kind k, t_cmd c, int unsigned sz,
                                      int unsigned off);
        t_stim s;
        s.kind             = k;
        s.req.command      = c;
        s.req.request_size = (c == CMD_ALLOC) ? FIELD_W'(sz) : FIELD_W'($urandom_range(0, FMAX));
        s.req.block_offset = (c == CMD_FREE) ? FIELD_W'(off) : FIELD_W'($urandom_range(0, FMAX));
        stim_q.push_back(s);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: holds start until the request is taken, then loads the next
    // ------------------------------------------------------------------------
    t_rsp rsp_due[$];
    t_req cur_req;
    t_rsp predicted;
    bit   holding;
    bit   idle_now;
    int   n_accepted;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start   <= 1'b0;
            holding = 1'b0;
        end else begin
            if (start && !busy) begin
                predicted = heap_command(cur_req);
                track_offsets(cur_req, predicted);
                rsp_due.push_back(predicted);
                n_accepted++;
                holding = 1'b0;
            end
            idle_now = (n_accepted < QUIET_LO || n_accepted >= QUIET_HI) &&
                       ($urandom_range(0, 99) < IDLE_PCT);
            if (!holding && stim_q.size() != 0 && !idle_now) begin
                cur_req = resolve_stim(stim_q.pop_front());
                i_req   <= cur_req;
                start   <= 1'b1;
                holding = 1'b1;
            end else if (!holding) begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each strobed response against the oldest prediction
    // ------------------------------------------------------------------------
    t_rsp want;
    int   n_errors;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rsp_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("[%0t] response with none pending: offset %0d success %0b",
                             $realtime, o_rsp.data_offset, o_rsp.success);
            end else begin
                want = rsp_due.pop_front();
                if (o_rsp.data_offset !== want.data_offset ||
                    o_rsp.success !== want.success) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("[%0t] mismatch: exp offset %0d success %0b, got %0d %0b",
                                 $realtime, want.data_offset, want.success,
                                 o_rsp.data_offset, o_rsp.success);
                end
            end
        end
    end

    // Watchdog: cycles with no request taken and no response
    int idle_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WDOG_LIMIT) begin
            $display("first_fit_heap_allocator regression: fail");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    int unsigned roll;
    int unsigned roll2;
    int unsigned sz;

    initial begin
        // heap after reset: a single free block spanning the whole heap
        for (int i = 0; i < SLOTS; i++) begin
            blk_size[i] = 0;
            blk_free[i] = 1'b0;
        end
        hdr_write(0, HEAP - HDR, 1'b1);

        // directed: oversized, exact whole-heap fit, allocate with no space left
        push_stim(STIM_FIXED, CMD_ALLOC, FMAX, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, HEAP, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, HEAP - HDR, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, 0, 0);
        push_stim(STIM_FIXED, CMD_FREE, 0, HDR);
        // zero-byte allocate, rounding of small sizes
        push_stim(STIM_FIXED, CMD_ALLOC, 0, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, 1, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, 7, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, 8, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, 9, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, 16, 0);
        push_stim(STIM_FIXED, CMD_ALLOC, 8, 0);
        // reuse a small hole whose remainder is too small to split
        push_stim(STIM_FIXED, CMD_FREE, 0, 144);
        push_stim(STIM_FIXED, CMD_ALLOC, 8, 0);
        // free without merge, free with merge, double free, free inside a block
        push_stim(STIM_FIXED, CMD_FREE, 0, 48);
        push_stim(STIM_FIXED, CMD_FREE, 0, 80);
        push_stim(STIM_FIXED, CMD_FREE, 0, 48);
        push_stim(STIM_FIXED, CMD_FREE, 0, 80);
        // null, below the header, unaligned, beyond the heap
        push_stim(STIM_FIXED, CMD_FREE, 0, 0);
        push_stim(STIM_FIXED, CMD_FREE, 0, 5);
        push_stim(STIM_FIXED, CMD_FREE, 0, HDR - 1);
        push_stim(STIM_FIXED, CMD_FREE, 0, HDR + 1);
        push_stim(STIM_FIXED, CMD_FREE, 0, FMAX);
        push_stim(STIM_FIXED, CMD_FREE, 0, HDR);

        // random: mostly allocate/free of live blocks, some double and stray frees
        for (int i = 0; i < N_RANDOM; i++) begin
            roll  = $urandom_range(0, 99);
            roll2 = $urandom_range(0, 99);
            if (roll < 45) begin
                if (roll2 < 70)      sz = $urandom_range(0, 200);
                else if (roll2 < 92) sz = $urandom_range(0, 8192);
                else                 sz = $urandom_range(0, FMAX);
                push_stim(STIM_ALLOC, CMD_ALLOC, sz, 0);
            end else if (roll < 80) begin
                push_stim(STIM_FREE_LIVE, CMD_FREE, 0, 0);
            end else if (roll < 88) begin
                push_stim(STIM_FREE_STALE, CMD_FREE, 0, $urandom_range(0, FMAX));
            end else begin
                if (roll2 < 25)      sz = 0;
                else if (roll2 < 50) sz = $urandom_range(1, HDR - 1);
                else if (roll2 < 75) sz = $urandom_range(HDR, 4096);
                else                 sz = $urandom_range(0, FMAX);
                push_stim(STIM_FIXED, CMD_FREE, 0, sz);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || holding || rsp_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        n_errors += rsp_due.size();
        if (n_errors == 0)
            $display("first_fit_heap_allocator regression: pass");
        else
            $display("first_fit_heap_allocator regression: fail");
        $finish;
    end

endmodule
